FILE: hw/rtl/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

    // Default sizing of the search engine.
    localparam int PAT_MAX_DEF   = 32;
    localparam int POS_WIDTH_DEF = 16;

    // Width of the reported match start, fixed by the result format.
    localparam int MATCH_START_W = 16;

    // Request kinds.
    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } t_kind;

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

    // Maps a-z to A-Z when folding is enabled, leaves every other byte alone.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
        logic [7:0] r;
        r = b;
        if (fold && (b >= ASCII_LOWER_A) && (b <= ASCII_LOWER_Z)) begin
            r = b - ASCII_CASE_OFS;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/substring_search_case_fold.sv
`timescale 1ns / 1ps

// Channel   Signals                                   Direction
// --------  ----------------------------------------  ---------
// input     i_in_valid, o_in_ready, i_kind, i_value,  in
//           i_last
// output    o_out_valid, i_out_ready, o_found,        out
//           o_match_start, o_pattern_truncated,
//           o_end_of_text
// config    i_cfg_wr_en, i_cfg_wr_data (fold_case)    in
//
// A request is processed from the input register; a text byte's result then
// sits in the output register until it is taken. One request per cycle is
// sustained while the output is not stalled: the compare bank and shift-and
// update are combinational. Reset (synchronous, active low) empties both
// registers, sets fold_case and clears pattern and search state. A stalled
// output holds its result; a pattern byte still retires behind it, a text waits.
module substring_search_case_fold
    import ssc_pkg::*;
#(
    parameter int PAT_MAX   = PAT_MAX_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_kind,
    input  logic [7:0]               i_value,
    input  logic                     i_last,

    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_found,
    output logic [MATCH_START_W-1:0] o_match_start,
    output logic                     o_pattern_truncated,
    output logic                     o_end_of_text,

    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data
);

    localparam int LEN_W = $clog2(PAT_MAX + 1);
    localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam logic [POS_WIDTH-1:0] POS_LIMIT = '1;

    // Input register.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_value;
    logic       r_in_last;

    // Pattern and search state.
    logic                 r_fold_case;
    logic [LEN_W-1:0]     r_len,       n_len;
    logic                 r_load_done, n_load_done;
    logic                 r_trunc,     n_trunc;
    logic [PAT_MAX-1:0]   r_vec,       n_vec;
    logic [POS_WIDTH-1:0] r_pos,       n_pos;
    logic                 r_found,     n_found;
    logic [POS_WIDTH-1:0] r_fpos,      n_fpos;

    // Output register.
    logic                     r_out_valid;
    logic                     r_out_found;
    logic [MATCH_START_W-1:0] r_out_start;
    logic                     r_out_trunc;
    logic                     r_out_last;

    logic               out_free;
    logic               is_text;
    logic               fire;
    logic               fire_pat;
    logic               fire_text;
    logic [LEN_W-1:0]   len_base;
    logic               trunc_base;
    logic               store_wr;
    logic [PAT_MAX-1:0] eq;
    logic [PAT_MAX-1:0] vec_step;
    logic [IDX_W-1:0]   tail_idx;
    logic               hit;
    logic [POS_WIDTH-1:0] start_pos;

    // The output register frees up when empty or being drained this cycle.
    assign out_free  = !r_out_valid || i_out_ready;
    assign is_text   = (t_kind'(r_in_kind) == KIND_TEXT);
    // Pattern requests never need the output register, so they retire freely.
    assign fire      = r_in_valid && (!is_text || out_free);
    assign fire_pat  = fire && !is_text;
    assign fire_text = fire && is_text;
    assign o_in_ready = !r_in_valid || fire;

    // A pattern byte after a completed pattern starts a new one.
    assign len_base   = r_load_done ? '0 : r_len;
    assign trunc_base = r_load_done ? 1'b0 : r_trunc;
    assign store_wr   = fire_pat && (len_base < LEN_W'(PAT_MAX));

    ssc_match #(
        .PAT_MAX (PAT_MAX)
    ) u_match (
        .i_clk       (i_clk),
        .i_wr_en     (store_wr),
        .i_wr_addr   (len_base[IDX_W-1:0]),
        .i_wr_data   (r_in_value),
        .i_fold_case (r_fold_case),
        .i_len       (r_len),
        .i_text_byte (r_in_value),
        .o_eq        (eq)
    );

    // Shift-and step: bit i means the text ending here matches prefix i+1.
    assign vec_step  = ((r_vec << 1) | PAT_MAX'(1)) & eq;
    assign tail_idx  = IDX_W'(r_len - LEN_W'(1));
    assign hit       = (r_len != '0) && !r_found && vec_step[tail_idx];
    assign start_pos = r_pos - POS_WIDTH'(tail_idx);

    always_comb begin
        n_len       = r_len;
        n_load_done = r_load_done;
        n_trunc     = r_trunc;
        n_vec       = r_vec;
        n_pos       = r_pos;
        n_found     = r_found;
        n_fpos      = r_fpos;
        if (fire_pat) begin
            n_len       = store_wr ? (len_base + LEN_W'(1)) : len_base;
            n_trunc     = trunc_base || !store_wr;
            n_load_done = r_in_last;
            n_vec       = '0;
            n_pos       = '0;
            n_found     = 1'b0;
            n_fpos      = '0;
        end else if (fire_text) begin
            n_vec = vec_step;
            if (hit) begin
                n_found = 1'b1;
                n_fpos  = start_pos;
            end
            if (r_pos != POS_LIMIT) begin
                n_pos = r_pos + POS_WIDTH'(1);
            end
            // End of a text string: the next text starts a fresh search.
            if (r_in_last) begin
                n_vec   = '0;
                n_pos   = '0;
                n_found = 1'b0;
                n_fpos  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fold_case <= 1'b1;
            r_len       <= '0;
            r_load_done <= 1'b1;
            r_trunc     <= 1'b0;
            r_vec       <= '0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_fpos      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire_text) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_fold_case <= i_cfg_wr_data;
            end
            r_len       <= n_len;
            r_load_done <= n_load_done;
            r_trunc     <= n_trunc;
            r_vec       <= n_vec;
            r_pos       <= n_pos;
            r_found     <= n_found;
            r_fpos      <= n_fpos;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_kind  <= i_kind;
            r_in_value <= i_value;
            r_in_last  <= i_last;
        end
        if (fire_text) begin
            r_out_found <= r_found || hit;
            if (r_found) begin
                r_out_start <= MATCH_START_W'(r_fpos);
            end else if (hit) begin
                r_out_start <= MATCH_START_W'(start_pos);
            end else begin
                r_out_start <= '0;
            end
            r_out_trunc <= r_trunc;
            r_out_last  <= r_in_last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_found             = r_out_found;
    assign o_match_start       = r_out_start;
    assign o_pattern_truncated = r_out_trunc;
    assign o_end_of_text       = r_out_last;

endmodule

FILE: hw/rtl/ssc_match.sv
`timescale 1ns / 1ps

// Pattern byte store with one comparator per entry. Each entry compares
// against the current text byte in parallel; entries at or beyond the loaded
// length never report equality.
module ssc_match
    import ssc_pkg::*;
#(
    parameter int PAT_MAX = PAT_MAX_DEF,
    localparam int LEN_W  = $clog2(PAT_MAX + 1),
    localparam int IDX_W  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  logic [7:0]         i_wr_data,
    input  logic               i_fold_case,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [7:0]         i_text_byte,
    output logic [PAT_MAX-1:0] o_eq
);

    logic [7:0] r_store [PAT_MAX];
    logic [7:0] text_folded;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_addr] <= i_wr_data;
        end
    end

    assign text_folded = fold_byte(i_text_byte, i_fold_case);

    always_comb begin
        for (int i = 0; i < PAT_MAX; i++) begin
            o_eq[i] = (LEN_W'(i) < i_len) &&
                      (fold_byte(r_store[i], i_fold_case) == text_folded);
        end
    end

endmodule

FILE: test/ssc_checker.sv
`timescale 1ns / 1ps

module ssc_checker
    import ssc_pkg::*;
#(
    parameter int PAT_MAX   = PAT_MAX_DEF,
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  t_kind                    i_kind,
    input  logic [7:0]               i_value,
    input  logic                     i_last,

    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_found,
    input  logic [MATCH_START_W-1:0] i_match_start,
    input  logic                     i_trunc,
    input  logic                     i_eot,

    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_wr_data,

    output int                       o_results_due,
    output int                       o_fail_count
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [POS_WIDTH-1:0] POS_SAT = '1;

    typedef struct packed {
        logic                     found;
        logic [MATCH_START_W-1:0] start;
        logic                     trunc;
        logic                     eot;
    } t_search_result;

    // Shadow copy of the search engine.
    logic [7:0]           pat_mem [PAT_MAX];
    int                   pat_len;
    logic [PAT_MAX-1:0]   prefix_hits;
    logic [POS_WIDTH-1:0] text_pos;
    logic                 hit_seen;
    logic [POS_WIDTH-1:0] hit_pos;
    logic                 pat_closed;
    logic                 pat_cut;
    logic                 fold_on;

    t_search_result search_results_due[$];
    int             mismatches;

    // Upper-casing a letter is clearing bit 5.
    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (fold_on && b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
            return {b[7:6], 1'b0, b[4:0]};
        end
        return b;
    endfunction

    task automatic clear_search();
        prefix_hits = '0;
        text_pos    = '0;
        hit_seen    = 1'b0;
        hit_pos     = '0;
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    task automatic shift_and_step(input t_kind k, input logic [7:0] v, input logic l);
        logic [7:0]         c;
        logic [PAT_MAX-1:0] eq;
        t_search_result     r;
        if (k == KIND_PATTERN) begin
            if (pat_closed) begin
                pat_len = 0;
                pat_cut = 1'b0;
            end
            if (pat_len < PAT_MAX) begin
                pat_mem[pat_len] = v;
                pat_len++;
            end else begin
                pat_cut = 1'b1;
            end
            pat_closed = l;
            clear_search();
        end else begin
            c  = upcase(v);
            eq = '0;
            for (int i = 0; i < PAT_MAX; i++) begin
                if (i < pat_len) begin
                    if (upcase(pat_mem[i]) == c) begin
                        eq[i] = 1'b1;
                    end
                end
            end
            prefix_hits = ((prefix_hits << 1) | PAT_MAX'(1)) & eq;
            if (pat_len > 0 && !hit_seen && prefix_hits[pat_len-1]) begin
                hit_seen = 1'b1;
                hit_pos  = text_pos - POS_WIDTH'(pat_len - 1);
            end
            r.found = hit_seen;
            r.start = hit_seen ? MATCH_START_W'(hit_pos) : '0;
            r.trunc = pat_cut;
            r.eot   = l;
            search_results_due.push_back(r);
            if (text_pos != POS_SAT) begin
                text_pos++;
            end
            if (l) begin
                clear_search();
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_search_result seen;
        t_search_result want;
        if (!i_rst_n) begin
            pat_len    = 0;
            pat_closed = 1'b1;
            pat_cut    = 1'b0;
            fold_on    = 1'b1;
            clear_search();
            search_results_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                fold_on = i_cfg_wr_data;
            end
            if (i_out_valid && i_out_ready) begin
                seen = {i_found, i_match_start, i_trunc, i_eot};
                if (search_results_due.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: found=%0d start=%0d trunc=%0d eot=%0d",
                        seen.found, seen.start, seen.trunc, seen.eot));
                end else begin
                    want = search_results_due.pop_front();
                    if (seen !== want) begin
                        note_failure($sformatf(
                            "mismatch: expected found=%0d start=%0d trunc=%0d eot=%0d, got found=%0d start=%0d trunc=%0d eot=%0d",
                            want.found, want.start, want.trunc, want.eot,
                            seen.found, seen.start, seen.trunc, seen.eot));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                shift_and_step(i_kind, i_value, i_last);
            end
        end
        o_results_due <= search_results_due.size();
        o_fail_count  <= mismatches;
    end

endmodule

FILE: test/substring_search_case_fold_tb.sv
`timescale 1ns / 1ps

module substring_search_case_fold_tb;
    import ssc_pkg::*;

    // A run is stopped when this many cycles pass with no request and no
    // result accepted.
    localparam int STALL_LIMIT   = 5000;
    // Cycles allowed after the last result so that a trailing pattern byte
    // can retire through the two-stage pipeline before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 430;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_ready;
    t_kind                    i_kind        = KIND_PATTERN;
    logic [7:0]               i_value       = 8'h00;
    logic                     i_last        = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready   = 1'b0;
    logic                     o_found;
    logic [MATCH_START_W-1:0] o_match_start;
    logic                     o_pattern_truncated;
    logic                     o_end_of_text;
    logic                     i_cfg_wr_en   = 1'b0;
    logic                     i_cfg_wr_data = 1'b0;

    int snd_idle_pct = 13;
    int rcv_idle_pct = 54;
    int sent_count   = 0;
    int stall_cycles = 0;
    int results_due;
    int fail_count;

    // The stimulus side keeps the pattern it loaded last so that texts can
    // embed copies of it and actually produce matches.
    logic [7:0] pat_image[$];

    always #5 i_clk = ~i_clk;

    substring_search_case_fold u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_kind              (i_kind),
        .i_value             (i_value),
        .i_last              (i_last),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_found             (o_found),
        .o_match_start       (o_match_start),
        .o_pattern_truncated (o_pattern_truncated),
        .o_end_of_text       (o_end_of_text),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data)
    );

    ssc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_found       (o_found),
        .i_match_start (o_match_start),
        .i_trunc       (o_pattern_truncated),
        .i_eot         (o_end_of_text),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_results_due (results_due),
        .o_fail_count  (fail_count)
    );

    // The receiver decides afresh every cycle whether to take a result. With
    // a percentage of zero it never stalls.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly a small mixed-case alphabet so that matches are frequent, and
    // otherwise any byte at all so that every bit of the value toggles.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) != 0) begin
            return 8'h41 + 8'($urandom_range(3)) + ($urandom_range(1) ? ASCII_CASE_OFS : 8'h00);
        end
        return 8'($urandom_range(255));
    endfunction

    // Presents one request at a falling edge, possibly after some idle
    // cycles, and holds it until the block accepts it. Valid is assigned
    // once per falling edge, so it never glitches between back-to-back
    // requests.
    task automatic send_req(input t_kind k, input logic [7:0] v, input logic l);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= k;
        i_value    <= v;
        i_last     <= l;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Stops sending and waits until every predicted result has been taken,
    // then lets the pipeline empty of any pattern byte still in flight.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle.
    task automatic set_fold(input logic f);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= f;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Random traffic. Most of it is well-formed: a pattern load followed by
    // texts that embed full or partial copies of that pattern in random case.
    // The rest is noise requests and text bytes slipped into a pattern load.
    task automatic run_traffic(input int n);
        int         goal;
        int         len;
        int         cut;
        int         pick;
        logic [7:0] b;
        logic [7:0] txt[$];
        goal = sent_count + n;
        while (sent_count < goal) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_req(t_kind'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
            end else if (pick < 28 || pat_image.size() == 0) begin
                // Now and then the pattern runs past the store capacity.
                if ($urandom_range(9) == 0) begin
                    len = $urandom_range(PAT_MAX_DEF + 8, PAT_MAX_DEF - 2);
                end else begin
                    len = $urandom_range(6, 1);
                end
                pat_image.delete();
                for (int i = 0; i < len; i++) begin
                    b = pick_byte();
                    pat_image.push_back(b);
                    if (i > 0 && $urandom_range(15) == 0) begin
                        send_req(KIND_TEXT, pick_byte(), 1'($urandom_range(1)));
                    end
                    send_req(KIND_PATTERN, b, i == len - 1);
                end
            end else begin
                txt.delete();
                len = $urandom_range(24, 1);
                while (txt.size() < len) begin
                    if ($urandom_range(2) == 0) begin
                        // Full copies give matches, cut copies give near misses.
                        if ($urandom_range(1) == 0) begin
                            cut = pat_image.size();
                        end else begin
                            cut = $urandom_range(pat_image.size(), 1);
                        end
                        for (int i = 0; i < cut; i++) begin
                            b = pat_image[i];
                            if (((b >= 8'h41 && b <= 8'h5a) ||
                                 (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z)) &&
                                $urandom_range(1) == 1) begin
                                b = b ^ ASCII_CASE_OFS;
                            end
                            txt.push_back(b);
                        end
                    end else begin
                        txt.push_back(pick_byte());
                    end
                end
                foreach (txt[i]) begin
                    send_req(KIND_TEXT, txt[i], i == txt.size() - 1);
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Text with no pattern loaded yet: an empty pattern never matches.
        send_req(KIND_TEXT, "a", 1'b1);

        // Folding is on after reset, so "aB" must be found in "xAbz" at 1.
        send_req(KIND_PATTERN, "a", 1'b0);
        send_req(KIND_PATTERN, "B", 1'b1);
        send_req(KIND_TEXT, "x", 1'b0);
        send_req(KIND_TEXT, "A", 1'b0);
        send_req(KIND_TEXT, "b", 1'b0);
        send_req(KIND_TEXT, "z", 1'b1);

        // Zero and all-ones bytes are ordinary data on both sides.
        send_req(KIND_PATTERN, 8'h00, 1'b0);
        send_req(KIND_PATTERN, 8'hff, 1'b1);
        send_req(KIND_TEXT, 8'h00, 1'b0);
        send_req(KIND_TEXT, 8'hff, 1'b1);

        // A text byte in the middle of a pattern load is matched against the
        // part loaded so far, and the next pattern byte extends that pattern.
        send_req(KIND_PATTERN, "Q", 1'b0);
        send_req(KIND_TEXT, "q", 1'b1);
        send_req(KIND_PATTERN, "R", 1'b1);

        // The second occurrence must not replace the first match start.
        send_req(KIND_TEXT, "q", 1'b0);
        send_req(KIND_TEXT, "r", 1'b0);
        send_req(KIND_TEXT, "q", 1'b0);
        send_req(KIND_TEXT, "r", 1'b1);
        settle();

        // Sender idles rarely, receiver often.
        set_fold(1'b0);
        run_traffic(PHASE_ITEMS);
        settle();

        // Sender idles often, receiver rarely.
        snd_idle_pct = 54;
        rcv_idle_pct = 13;
        set_fold(1'b1);
        run_traffic(PHASE_ITEMS);
        settle();

        // Full rate on both sides, with both fold settings.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_fold(1'b0);
        run_traffic(PHASE_ITEMS / 2);
        settle();
        set_fold(1'b1);
        run_traffic(PHASE_ITEMS / 2);
        settle();

        if (fail_count == 0 && results_due == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: substring_search_case_fold.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_match.sv
hw/rtl/substring_search_case_fold.sv
test/ssc_checker.sv
test/substring_search_case_fold_tb.sv
